/* hw/rtl/ptst_pkg.sv */
// ----------------------------------------------------------------------------
// ptst_pkg
// Shared types and codes for the periodic timer slot table.
// ----------------------------------------------------------------------------
package ptst_pkg;

  // payload field widths
  localparam int CMD_W  = 3;
  localparam int ID_W   = 8;
  localparam int RATE_W = 32;

  // command codes
  localparam logic [CMD_W-1:0] CMD_REQUEST = 3'd0;
  localparam logic [CMD_W-1:0] CMD_CANCEL  = 3'd1;
  localparam logic [CMD_W-1:0] CMD_RESET   = 3'd2;
  localparam logic [CMD_W-1:0] CMD_START   = 3'd3;
  localparam logic [CMD_W-1:0] CMD_STOP    = 3'd4;
  localparam logic [CMD_W-1:0] CMD_TICK    = 3'd5;

  // result status codes
  typedef enum logic [1:0] {
    ST_DONE   = 2'd0,
    ST_REJECT = 2'd1,
    ST_EXPIRY = 2'd2
  } status_t;

  // one slot as stored in the table memory
  typedef struct packed {
    logic [ID_W-1:0]   owner;
    logic [RATE_W-1:0] period;
    logic [RATE_W-1:0] counter;
    logic              running;
  } slot_t;

  // slot unit verdict for the slot under work
  typedef struct packed {
    logic  hit;    // free slot found, id matched or expiry
    logic  we;     // slot word must be written back
    slot_t wdata;
  } slot_res_t;

endpackage

/* hw/rtl/ptst_in_if.sv */
// ----------------------------------------------------------------------------
// ptst_in_if
// Command channel: valid/ready with command, client id and rate.
// ----------------------------------------------------------------------------
interface ptst_in_if import ptst_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  command;
  logic [ID_W-1:0]   client_id;
  logic [RATE_W-1:0] rate;

  modport source (output valid, command, client_id, rate, input ready);
  modport sink   (input valid, command, client_id, rate, output ready);
endinterface

/* hw/rtl/ptst_out_if.sv */
// ----------------------------------------------------------------------------
// ptst_out_if
// Result channel: valid/ready with status, expired id and last flag.
// ----------------------------------------------------------------------------
interface ptst_out_if import ptst_pkg::*; ();
  logic            valid;
  logic            ready;
  status_t         status;
  logic [ID_W-1:0] expired_id;
  logic            last;

  modport source (output valid, status, expired_id, last, input ready);
  modport sink   (input valid, status, expired_id, last, output ready);
endinterface

/* hw/rtl/ptst_cfg_if.sv */
// ----------------------------------------------------------------------------
// ptst_cfg_if
// Configuration write channel for the timer enable register.
// ----------------------------------------------------------------------------
interface ptst_cfg_if;
  logic valid;
  logic ready;
  logic timer_en;

  modport source (output valid, timer_en, input ready);
  modport sink   (input valid, timer_en, output ready);
endinterface

/* hw/rtl/ptst_ram.sv */
// ----------------------------------------------------------------------------
// ptst_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
module ptst_ram #(
  parameter  int WIDTH = 8,
  parameter  int DEPTH = 16,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* hw/rtl/ptst_slot_alu.sv */
// ----------------------------------------------------------------------------
// ptst_slot_alu
// Shared slot unit: free/match test, counter add and period compare.
// ----------------------------------------------------------------------------
module ptst_slot_alu import ptst_pkg::*; (
  input  logic [CMD_W-1:0]  command,
  input  logic [ID_W-1:0]   client_id,
  input  logic [RATE_W-1:0] rate,
  input  slot_t             cur,
  output slot_res_t         res
);

  logic              occupied;
  logic              match;
  logic [RATE_W-1:0] cnt_inc;
  logic              expiry;

  assign occupied = (cur.owner != '0);
  assign match    = occupied && (cur.owner == client_id);
  assign cnt_inc  = cur.running ? (cur.counter + RATE_W'(1)) : cur.counter;
  assign expiry   = occupied && (cnt_inc == cur.period);

  // per-command decision for the slot under work
  always_comb begin
    res.hit   = 1'b0;
    res.we    = 1'b0;
    res.wdata = cur;
    unique case (command)
      CMD_REQUEST: begin
        res.hit           = !occupied;
        res.we            = !occupied;
        res.wdata.owner   = client_id;
        res.wdata.period  = rate;
        res.wdata.counter = '0;
        res.wdata.running = 1'b0;
      end
      CMD_CANCEL: begin
        res.hit         = match;
        res.we          = match;
        res.wdata.owner = '0;
      end
      CMD_RESET: begin
        res.hit           = match;
        res.we            = match;
        res.wdata.counter = '0;
      end
      CMD_START: begin
        res.hit           = match;
        res.we            = match;
        res.wdata.running = 1'b1;
      end
      CMD_STOP: begin
        res.hit           = match;
        res.we            = match;
        res.wdata.running = 1'b0;
      end
      CMD_TICK: begin
        res.hit           = expiry;
        res.we            = occupied && (cur.running || expiry);
        res.wdata.counter = expiry ? '0 : cnt_inc;
      end
      default: begin
        res.hit = 1'b0;
      end
    endcase
  end

endmodule

/* hw/rtl/periodic_timer_slot_table_core.sv */
// ----------------------------------------------------------------------------
// periodic_timer_slot_table_core
// Table of periodic timer slots walked one slot per cycle, unless stalled, by a sequencer.
// ----------------------------------------------------------------------------
// Usage:
//   in_bus  : command beats (request, cancel, reset count, start, stop, tick)
//   out_bus : result beats; one per command, or one per expiry on a tick,
//             the final beat of a command carries last
//   cfg_bus : timer_en write; writing 1 clears the table, 0 keeps it
// Timing: a command walks the slot table in memory, one slot per cycle while
//   no stall holds the walk, through one shared add/compare unit. A command
//   over the whole table visits every slot before its final result;
//   a request ends at the first free slot, so it can be shorter. Commands
//   that need no walk (tick or request while off, unused codes) go straight
//   to the final result. The next command is taken once the final result is registered.
// Reset clears all slot valid bits (every slot reads free), timer_en and
//   the sequencer; the table memory itself needs no clearing pass.
// A stalled receiver holds the walk whenever a tick has a second expiry
//   ready while the previous result still sits in the output register.
// ----------------------------------------------------------------------------
module periodic_timer_slot_table_core import ptst_pkg::*; #(
  parameter int SLOTS = 10
) (
  input  logic  clk,
  input  logic  rst_n,
  ptst_in_if.sink    in_bus,
  ptst_out_if.source out_bus,
  ptst_cfg_if.sink   cfg_bus
);

  localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CW = $clog2(SLOTS + 1);

  typedef enum logic [1:0] {S_IDLE, S_WALK, S_FINISH} state_t;

  state_t            state_r, state_nxt;
  logic              timer_en_r, timer_en_nxt;
  logic [SLOTS-1:0]  valid_r, valid_nxt;
  logic [CMD_W-1:0]  cmd_r, cmd_nxt;
  logic [ID_W-1:0]   id_r, id_nxt;
  logic [RATE_W-1:0] rate_r, rate_nxt;
  status_t           fin_status_r, fin_status_nxt;
  logic [CW-1:0]     rd_cnt_r, rd_cnt_nxt;
  logic [AW-1:0]     pidx_r, pidx_nxt;
  logic              pv_r, pv_nxt;
  logic              pend_v_r, pend_v_nxt;
  logic [ID_W-1:0]   pend_id_r, pend_id_nxt;
  logic              out_valid_r, out_valid_nxt;
  status_t           out_status_r, out_status_nxt;
  logic [ID_W-1:0]   out_id_r, out_id_nxt;
  logic              out_last_r, out_last_nxt;

  logic              ram_we, ram_re;
  logic [$bits(slot_t)-1:0] ram_rdata;
  slot_t             slot_cur;
  slot_res_t         alu_res;
  logic              out_free, is_tick, is_req, stall, req_hit, more;
  logic              in_beat, cfg_beat;

  // slot table memory
  ptst_ram #(
    .WIDTH ($bits(slot_t)),
    .DEPTH (SLOTS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (pidx_r),
    .wdata (alu_res.wdata),
    .re    (ram_re),
    .raddr (rd_cnt_r[AW-1:0]),
    .rdata (ram_rdata)
  );

  // slot never written since clear reads as free
  assign slot_cur = valid_r[pidx_r] ? slot_t'(ram_rdata) : '0;

  ptst_slot_alu u_alu (
    .command   (cmd_r),
    .client_id (id_r),
    .rate      (rate_r),
    .cur       (slot_cur),
    .res       (alu_res)
  );

  // handshake and walk control terms
  assign in_beat  = in_bus.valid && in_bus.ready;
  assign cfg_beat = cfg_bus.valid && cfg_bus.ready;
  assign out_free = !out_valid_r || out_bus.ready;
  assign is_tick  = (cmd_r == CMD_TICK);
  assign is_req   = (cmd_r == CMD_REQUEST);
  assign stall    = pv_r && is_tick && alu_res.hit && pend_v_r && !out_free;
  assign req_hit  = pv_r && is_req && alu_res.hit;
  assign more     = (rd_cnt_r < CW'(SLOTS));
  assign ram_we   = (state_r == S_WALK) && pv_r && !stall && alu_res.we;
  assign ram_re   = (state_r == S_WALK) && !stall && !req_hit && more;

  // sequencer next state
  always_comb begin
    state_nxt      = state_r;
    timer_en_nxt   = timer_en_r;
    valid_nxt      = valid_r;
    cmd_nxt        = cmd_r;
    id_nxt         = id_r;
    rate_nxt       = rate_r;
    fin_status_nxt = fin_status_r;
    rd_cnt_nxt     = rd_cnt_r;
    pidx_nxt       = pidx_r;
    pv_nxt         = pv_r;
    pend_v_nxt     = pend_v_r;
    pend_id_nxt    = pend_id_r;
    out_valid_nxt  = out_valid_r;
    out_status_nxt = out_status_r;
    out_id_nxt     = out_id_r;
    out_last_nxt   = out_last_r;

    if (out_valid_r && out_bus.ready) begin
      out_valid_nxt = 1'b0;
    end

    if (ram_we) begin
      valid_nxt[pidx_r] = 1'b1;
    end

    // configuration write
    if (cfg_beat) begin
      timer_en_nxt = cfg_bus.timer_en;
      if (cfg_bus.timer_en) begin
        valid_nxt = '0;
      end
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_beat) begin
          cmd_nxt    = in_bus.command;
          id_nxt     = in_bus.client_id;
          rate_nxt   = in_bus.rate;
          rd_cnt_nxt = '0;
          pv_nxt     = 1'b0;
          pend_v_nxt = 1'b0;
          priority if (in_bus.command == CMD_REQUEST && !timer_en_r) begin
            fin_status_nxt = ST_REJECT;
            state_nxt      = S_FINISH;
          end else if (in_bus.command == CMD_TICK && !timer_en_r) begin
            fin_status_nxt = ST_DONE;
            state_nxt      = S_FINISH;
          end else if (in_bus.command == CMD_REQUEST) begin
            fin_status_nxt = ST_REJECT;
            state_nxt      = S_WALK;
          end else if (in_bus.command <= CMD_TICK) begin
            fin_status_nxt = ST_DONE;
            state_nxt      = S_WALK;
          end else begin
            fin_status_nxt = ST_DONE;
            state_nxt      = S_FINISH;
          end
        end
      end
      S_WALK: begin
        if (!stall) begin
          // expiry: flush the held one, hold the new one
          if (pv_r && is_tick && alu_res.hit) begin
            if (pend_v_r) begin
              out_valid_nxt  = 1'b1;
              out_status_nxt = ST_EXPIRY;
              out_id_nxt     = pend_id_r;
              out_last_nxt   = 1'b0;
            end
            pend_v_nxt  = 1'b1;
            pend_id_nxt = slot_cur.owner;
          end
          priority if (req_hit) begin
            fin_status_nxt = ST_DONE;
            pv_nxt         = 1'b0;
            state_nxt      = S_FINISH;
          end else if (more) begin
            pidx_nxt   = rd_cnt_r[AW-1:0];
            rd_cnt_nxt = rd_cnt_r + CW'(1);
            pv_nxt     = 1'b1;
          end else begin
            pv_nxt    = 1'b0;
            state_nxt = S_FINISH;
          end
        end
      end
      S_FINISH: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_last_nxt  = 1'b1;
          if (is_tick && pend_v_r) begin
            out_status_nxt = ST_EXPIRY;
            out_id_nxt     = pend_id_r;
          end else begin
            out_status_nxt = fin_status_r;
            out_id_nxt     = '0;
          end
          pend_v_nxt = 1'b0;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      timer_en_r   <= 1'b0;
      valid_r      <= '0;
      pv_r         <= 1'b0;
      pend_v_r     <= 1'b0;
      out_valid_r  <= 1'b0;
      rd_cnt_r     <= '0;
      fin_status_r <= ST_DONE;
    end else begin
      state_r      <= state_nxt;
      timer_en_r   <= timer_en_nxt;
      valid_r      <= valid_nxt;
      pv_r         <= pv_nxt;
      pend_v_r     <= pend_v_nxt;
      out_valid_r  <= out_valid_nxt;
      rd_cnt_r     <= rd_cnt_nxt;
      fin_status_r <= fin_status_nxt;
    end
    cmd_r        <= cmd_nxt;
    id_r         <= id_nxt;
    rate_r       <= rate_nxt;
    pidx_r       <= pidx_nxt;
    pend_id_r    <= pend_id_nxt;
    out_status_r <= out_status_nxt;
    out_id_r     <= out_id_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign in_bus.ready       = (state_r == S_IDLE);
  assign cfg_bus.ready      = 1'b1;
  assign out_bus.valid      = out_valid_r;
  assign out_bus.status     = out_status_r;
  assign out_bus.expired_id = out_id_r;
  assign out_bus.last       = out_last_r;

  // write-back never lands on the slot being fetched
  a_no_rw_clash: assert property (@(posedge clk) disable iff (!rst_n)
    (ram_we && ram_re) |-> (pidx_r != rd_cnt_r[AW-1:0]))
    else $error("slot write and fetch hit the same slot");

  // fetched slot data only exists during a walk
  a_pv_in_walk: assert property (@(posedge clk) disable iff (!rst_n)
    pv_r |-> (state_r == S_WALK))
    else $error("slot data pending outside walk");

  // a held expiry belongs to a tick
  a_pend_tick: assert property (@(posedge clk) disable iff (!rst_n)
    pend_v_r |-> is_tick)
    else $error("expiry held for a non-tick command");

  // a non-final beat is always an expiry
  a_nonlast_expiry: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_last_r) |-> (out_status_r == ST_EXPIRY))
    else $error("non-final result beat is not an expiry");

  // finishing with a free output register yields a final beat
  a_finish_last: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FINISH && out_free) |=> (out_valid_r && out_last_r))
    else $error("command finished without a final beat");

endmodule

/* tb/ptst_timer_monitor.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ptst_timer_monitor
// Watches the command, result and timer enable channels of the slot table. It
// keeps its own copy of the slot table and computes the result beats that
// each accepted command must produce. Every result beat is compared with the
// oldest pending one, and the mismatch count is handed to the top.
// ----------------------------------------------------------------------------
module ptst_timer_monitor import ptst_pkg::*; #(
  parameter int SLOTS = 10
) (
  input  logic        clk,
  input  logic        rst_n,
  ptst_in_if          in_mon,
  ptst_out_if         out_mon,
  ptst_cfg_if         cfg_mon,
  output int unsigned pending_cnt,
  output int unsigned error_cnt
);

  typedef struct packed {
    status_t         status;
    logic [ID_W-1:0] id;
    logic            last;
  } timer_result_t;

  // shadow slot table
  logic [ID_W-1:0]   tbl_owner  [SLOTS];
  logic [RATE_W-1:0] tbl_period [SLOTS];
  logic [RATE_W-1:0] tbl_count  [SLOTS];
  logic              tbl_run    [SLOTS];
  logic              timer_en_m;

  timer_result_t     owed_results[$];
  int unsigned       mismatch_cnt = 0;

  assign error_cnt = mismatch_cnt;

  function automatic void clear_slots();
    for (int s = 0; s < SLOTS; s++) begin
      tbl_owner[s]  = '0;
      tbl_period[s] = '0;
      tbl_count[s]  = '0;
      tbl_run[s]    = 1'b0;
    end
  endfunction

  function automatic void owe_result(status_t st, logic [ID_W-1:0] id, logic last);
    timer_result_t r;
    r.status = st;
    r.id     = id;
    r.last   = last;
    owed_results.push_back(r);
  endfunction

  // apply one command to the shadow table and queue its result beats
  function automatic void advance_slot_table(logic [CMD_W-1:0] cmd,
                                             logic [ID_W-1:0] id,
                                             logic [RATE_W-1:0] rate);
    bit placed;
    int hits;
    placed = 1'b0;
    hits   = 0;
    case (cmd)
      CMD_REQUEST: begin
        if (timer_en_m) begin
          for (int s = 0; s < SLOTS; s++) begin
            if (!placed && tbl_owner[s] == '0) begin
              tbl_owner[s]  = id;
              tbl_period[s] = rate;
              tbl_count[s]  = '0;
              tbl_run[s]    = 1'b0;
              placed        = 1'b1;
            end
          end
        end
        owe_result(placed ? ST_DONE : ST_REJECT, '0, 1'b1);
      end
      CMD_CANCEL, CMD_RESET, CMD_START, CMD_STOP: begin
        for (int s = 0; s < SLOTS; s++) begin
          if (tbl_owner[s] == id) begin
            if (cmd == CMD_CANCEL)     tbl_owner[s] = '0;
            else if (cmd == CMD_RESET) tbl_count[s] = '0;
            else                       tbl_run[s]   = (cmd == CMD_START);
          end
        end
        owe_result(ST_DONE, '0, 1'b1);
      end
      CMD_TICK: begin
        if (timer_en_m) begin
          for (int s = 0; s < SLOTS; s++) begin
            if (tbl_owner[s] != '0) begin
              if (tbl_run[s]) tbl_count[s] = tbl_count[s] + RATE_W'(1);
              // compared even when stopped, so a stopped slot with a zero rate fires every tick
              if (tbl_count[s] == tbl_period[s]) begin
                owe_result(ST_EXPIRY, tbl_owner[s], 1'b0);
                tbl_count[s] = '0;
                hits++;
              end
            end
          end
        end
        if (hits > 0) owed_results[owed_results.size()-1].last = 1'b1;
        else          owe_result(ST_DONE, '0, 1'b1);
      end
      default: owe_result(ST_DONE, '0, 1'b1);
    endcase
  endfunction

  // result beats are checked before the command of the same edge is applied
  always @(posedge clk) begin
    timer_result_t want;
    if (!rst_n) begin
      clear_slots();
      timer_en_m = 1'b0;
      owed_results.delete();
      pending_cnt <= 0;
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        if (owed_results.size() == 0) begin
          if (mismatch_cnt < 10)
            $display("%0t: result beat with nothing pending: status=%0d id=%0d last=%0d",
                     $realtime, out_mon.status, out_mon.expired_id, out_mon.last);
          mismatch_cnt++;
        end else begin
          want = owed_results.pop_front();
          if (out_mon.status !== want.status || out_mon.expired_id !== want.id ||
              out_mon.last !== want.last) begin
            if (mismatch_cnt < 10)
              $display("%0t: mismatch exp st=%0d id=%0d last=%0d got st=%0d id=%0d last=%0d",
                       $realtime, want.status, want.id, want.last,
                       out_mon.status, out_mon.expired_id, out_mon.last);
            mismatch_cnt++;
          end
        end
      end
      // writing 1 clears the table, writing 0 keeps it
      if (cfg_mon.valid && cfg_mon.ready) begin
        if (cfg_mon.timer_en) clear_slots();
        timer_en_m = cfg_mon.timer_en;
      end
      if (in_mon.valid && in_mon.ready)
        advance_slot_table(in_mon.command, in_mon.client_id, in_mon.rate);
      pending_cnt <= owed_results.size();
    end
  end

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Drives the periodic timer slot table with directed and random commands,
// timer enable writes and random gaps and stalls on both channels. The monitor
// beside the block predicts and checks every result beat; this module gives
// the verdict once all results have drained.
// ----------------------------------------------------------------------------
module tb_top;
  import ptst_pkg::*;

  localparam int          SLOTS        = 10;
  localparam int unsigned LIMIT_CYCLES = 400000;

  // codes with no command behind them
  localparam logic [CMD_W-1:0] CMD_SPARE_6 = 3'd6;
  localparam logic [CMD_W-1:0] CMD_SPARE_7 = 3'd7;

  logic        clk;
  logic        rst_n;
  bit          steady = 1'b0;
  int unsigned hold_left = 0;
  int unsigned cycle_cnt = 0;
  int unsigned pending_cnt;
  int unsigned error_cnt;

  ptst_in_if  in_bus ();
  ptst_out_if out_bus ();
  ptst_cfg_if cfg_bus ();

  periodic_timer_slot_table_core #(.SLOTS(SLOTS)) dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bus  (in_bus),
    .out_bus (out_bus),
    .cfg_bus (cfg_bus)
  );

  ptst_timer_monitor #(.SLOTS(SLOTS)) u_timer_monitor (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_mon      (in_bus),
    .out_mon     (out_bus),
    .cfg_mon     (cfg_bus),
    .pending_cnt (pending_cnt),
    .error_cnt   (error_cnt)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // run limit
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == LIMIT_CYCLES) begin
      $display("tb_top: FAIL");
      $finish;
    end
  end

  // mostly short, a few long
  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // result side back-pressure
  always @(posedge clk) begin
    if (!rst_n) begin
      out_bus.ready <= 1'b0;
      hold_left     <= 0;
    end else if (steady) begin
      out_bus.ready <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else begin
      out_bus.ready <= ($urandom_range(0, 3) != 0);
      hold_left     <= idle_len();
    end
  end

  // one command beat, then an optional gap
  task automatic send_cmd(input logic [CMD_W-1:0] cmd, input logic [ID_W-1:0] id,
                          input logic [RATE_W-1:0] rate);
    int unsigned gap;
    in_bus.valid     <= 1'b1;
    in_bus.command   <= cmd;
    in_bus.client_id <= id;
    in_bus.rate      <= rate;
    @(posedge clk);
    while (!in_bus.ready) @(posedge clk);
    gap = steady ? 0 : idle_len();
    if (gap > 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // hold the sender until every owed result has come out
  task automatic drain_results();
    in_bus.valid <= 1'b0;
    @(posedge clk);
    while (pending_cnt != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_timer_en(input logic on);
    cfg_bus.valid    <= 1'b1;
    cfg_bus.timer_en <= on;
    @(posedge clk);
    while (!cfg_bus.ready) @(posedge clk);
    cfg_bus.valid <= 1'b0;
    @(posedge clk);
  endtask

  // mostly commands on a small id pool with short rates, some noise
  task automatic random_cmd();
    int unsigned      r;
    logic [CMD_W-1:0] cmd;
    logic [ID_W-1:0]  id;
    logic [RATE_W-1:0] rate;
    r    = $urandom_range(0, 99);
    id   = ID_W'($urandom_range(1, 12));
    rate = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 4);
    if (r < 35)      cmd = CMD_TICK;
    else if (r < 52) cmd = CMD_REQUEST;
    else if (r < 65) cmd = CMD_START;
    else if (r < 72) cmd = CMD_STOP;
    else if (r < 80) cmd = CMD_RESET;
    else if (r < 88) cmd = CMD_CANCEL;
    else begin
      cmd  = CMD_W'($urandom_range(0, 7));
      id   = ID_W'($urandom_range(0, 255));
      rate = $urandom;
    end
    send_cmd(cmd, id, rate);
  endtask

  task automatic random_phase(input int unsigned n_items, input int unsigned drain_at);
    for (int unsigned i = 0; i < n_items; i++) begin
      if (i == drain_at) drain_results();
      random_cmd();
    end
  endtask

  initial begin
    in_bus.valid     <= 1'b0;
    in_bus.command   <= CMD_REQUEST;
    in_bus.client_id <= '0;
    in_bus.rate      <= '0;
    cfg_bus.valid    <= 1'b0;
    cfg_bus.timer_en <= 1'b0;
    rst_n            <= 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // timer off: request rejected, tick and spare codes do nothing
    send_cmd(CMD_REQUEST, 8'd5, 32'd3);
    send_cmd(CMD_TICK, 8'd0, 32'd0);
    send_cmd(CMD_SPARE_6, 8'hff, 32'hffff_ffff);
    send_cmd(CMD_SPARE_7, 8'h00, 32'h0000_0000);
    send_cmd(CMD_CANCEL, 8'd0, 32'd0);
    drain_results();
    write_timer_en(1'b1);

    // extreme rates, zero id, zero rate firing while stopped
    send_cmd(CMD_REQUEST, 8'hff, 32'hffff_ffff);
    send_cmd(CMD_REQUEST, 8'd1, 32'd0);
    send_cmd(CMD_REQUEST, 8'd0, 32'd5);
    send_cmd(CMD_TICK, 8'd0, 32'd0);
    send_cmd(CMD_START, 8'hff, 32'd0);
    send_cmd(CMD_TICK, 8'd0, 32'd0);
    send_cmd(CMD_RESET, 8'hff, 32'd0);
    send_cmd(CMD_STOP, 8'hff, 32'd0);
    // fill the table, then one more request is rejected
    for (int k = 2; k < 10; k++) send_cmd(CMD_REQUEST, k[ID_W-1:0], 32'd0);
    send_cmd(CMD_REQUEST, 8'd77, 32'd1);
    send_cmd(CMD_CANCEL, 8'd1, 32'd0);
    send_cmd(CMD_REQUEST, 8'd11, 32'd0);
    // many expiries on one tick
    send_cmd(CMD_TICK, 8'd0, 32'd0);

    // back to back, no stalls
    steady = 1'b1;
    random_phase(35, 35);
    drain_results();
    steady = 1'b0;

    // fresh table with gaps and stalls on both sides
    write_timer_en(1'b1);
    random_phase(45, 20);
    drain_results();

    // timer off keeps the table; ticks idle, requests rejected
    write_timer_en(1'b0);
    random_phase(25, 25);
    drain_results();

    // repeated enable clears again
    write_timer_en(1'b1);
    write_timer_en(1'b1);
    random_phase(45, 30);
    drain_results();

    if (error_cnt == 0)
      $display("tb_top: PASS");
    else
      $display("tb_top: FAIL");
    $finish;
  end

endmodule

/* periodic_timer_slot_table_core.f */
hw/rtl/ptst_pkg.sv
hw/rtl/ptst_in_if.sv
hw/rtl/ptst_out_if.sv
hw/rtl/ptst_cfg_if.sv
hw/rtl/ptst_ram.sv
hw/rtl/ptst_slot_alu.sv
hw/rtl/periodic_timer_slot_table_core.sv
tb/ptst_timer_monitor.sv
tb/tb_top.sv
